// ----- rtl/core/mls_pkg.sv -----
// mls_pkg: shared constants, register codes, cell control struct and the
// primitive-polynomial tap table for the MLS generator.
// No dependencies.
package mls_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 64;
  localparam int unsigned LEN_W          = 7;
  localparam int unsigned STATE_W        = 64;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_ADDR_W     = 4;
  localparam int unsigned IN_DATA_W      = 8;
  localparam int unsigned OUT_DATA_W     = 72;

  localparam logic [LEN_W-1:0]   LEN_RESET  = 7'd64;
  localparam logic [STATE_W-1:0] SEED_RESET = '0;

  // register select: paddr bit 3 (registers sit at 0x0 and 0x8)
  localparam logic REG_SEQ_LENGTH = 1'b0;
  localparam logic REG_SEED       = 1'b1;

  // broadcast control shared by every cell of the row
  typedef struct packed {
    logic load;   // reload from seed
    logic step;   // shift one place toward bit 0
    logic fb;     // parity of the tapped bits
  } cell_ctl_t;

  function automatic logic [STATE_W-1:0] t2(input int unsigned a);
    t2 = 64'h1 | (64'h1 << a);
  endfunction

  function automatic logic [STATE_W-1:0] t4(input int unsigned a, input int unsigned b,
                                            input int unsigned c);
    t4 = 64'h1 | (64'h1 << a) | (64'h1 << b) | (64'h1 << c);
  endfunction

  // n ones from bit 0 up; n = 64 gives all ones
  function automatic logic [STATE_W-1:0] len_mask(input logic [LEN_W-1:0] n);
    len_mask = ~({STATE_W{1'b1}} << n);
  endfunction

  // tap mask per active length; bit 0 is always tapped
  function automatic logic [STATE_W-1:0] tap_mask(input logic [LEN_W-1:0] n);
    logic [STATE_W-1:0] t;
    t = '0;
    case (n)
      7'd1:  t = 64'h1;
      7'd2:  t = t2(1);
      7'd3:  t = t2(1);
      7'd4:  t = t2(1);
      7'd5:  t = t2(2);
      7'd6:  t = t2(1);
      7'd7:  t = t2(1);
      7'd8:  t = t4(1, 5, 6);
      7'd9:  t = t2(4);
      7'd10: t = t2(3);
      7'd11: t = t2(2);
      7'd12: t = t4(3, 4, 7);
      7'd13: t = t4(1, 3, 4);
      7'd14: t = t4(1, 11, 12);
      7'd15: t = t2(1);
      7'd16: t = t4(2, 3, 5);
      7'd17: t = t2(3);
      7'd18: t = t2(7);
      7'd19: t = t4(1, 5, 6);
      7'd20: t = t2(3);
      7'd21: t = t2(2);
      7'd22: t = t2(1);
      7'd23: t = t2(5);
      7'd24: t = t4(1, 3, 4);
      7'd25: t = t2(3);
      7'd26: t = t4(1, 7, 8);
      7'd27: t = t4(1, 7, 8);
      7'd28: t = t2(3);
      7'd29: t = t2(2);
      7'd30: t = t4(1, 15, 16);
      7'd31: t = t2(3);
      7'd32: t = t4(1, 27, 28);
      7'd33: t = t2(13);
      7'd34: t = t4(1, 14, 15);
      7'd35: t = t2(2);
      7'd36: t = t2(11);
      7'd37: t = t4(2, 10, 12);
      7'd38: t = t4(1, 5, 6);
      7'd39: t = t2(4);
      7'd40: t = t4(2, 19, 21);
      7'd41: t = t2(3);
      7'd42: t = t4(1, 22, 23);
      7'd43: t = t4(1, 5, 6);
      7'd44: t = t4(1, 26, 27);
      7'd45: t = t4(1, 3, 4);
      7'd46: t = t4(1, 20, 21);
      7'd47: t = t2(5);
      7'd48: t = t4(1, 27, 28);
      7'd49: t = t2(9);
      7'd50: t = t4(1, 26, 27);
      7'd51: t = t4(1, 15, 16);
      7'd52: t = t2(3);
      7'd53: t = t4(1, 15, 16);
      7'd54: t = t4(1, 36, 37);
      7'd55: t = t2(24);
      7'd56: t = t4(1, 21, 22);
      7'd57: t = t2(7);
      7'd58: t = t2(19);
      7'd59: t = t4(1, 21, 22);
      7'd60: t = t2(1);
      7'd61: t = t4(1, 15, 16);
      7'd62: t = t4(1, 56, 57);
      7'd63: t = t2(1);
      7'd64: t = t4(1, 3, 4);
      default: t = '0;
    endcase
    tap_mask = t;
  endfunction

endpackage

// ----- rtl/core/mls_cell.sv -----
// mls_cell: one bit of the LFSR row; loads, or takes its left neighbor's
// bit (or the feedback at the top active place) on each step.
// Depends on mls_pkg.
module mls_cell (
  input  logic              clk,
  input  mls_pkg::cell_ctl_t ctl,
  input  logic              is_top,
  input  logic              load_bit,
  input  logic              right,
  output logic              q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_bit;
    end else if (ctl.step) begin
      q <= is_top ? ctl.fb : right;
    end
  end

endmodule

// ----- rtl/core/mls_sequence_generator.sv -----
// An accepted tick with advance set lands in the output register, or in the skid entry.
// Throughput: one tick per cycle while s_tready is high; the tap parity is combinational.
// Output register plus skid entry: s_tready falls once a request lands in the skid entry
// during a stall, and rises again the cycle after m_tready returns.
// Reset (rst, synchronous): seq_length = 64 (saturated to MAX_LENGTH), seed = 0,
// every active bit set, output empty. Depends on mls_pkg and mls_cell.
module mls_sequence_generator #(
  parameter int unsigned MAX_LENGTH = mls_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // tick requests
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mls_pkg::IN_DATA_W-1:0]       s_tdata,   // [0] advance, [7:1] zero
  // results
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mls_pkg::OUT_DATA_W-1:0]      m_tdata,   // [0] out_bit, [2:1] sample,
                                                         // [66:3] period, [71:67] zero
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mls_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mls_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mls_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam logic [mls_pkg::LEN_W-1:0] LEN_MAX = mls_pkg::LEN_W'(MAX_LENGTH);

  // ---------------------------------------------------------------------------
  // Configuration registers. paddr[3] picks the register; the lower address
  // bits alias within each 8-byte slot.
  // ---------------------------------------------------------------------------
  logic                              wr;
  logic                              wr_len;
  logic                              wr_seed;
  logic [mls_pkg::LEN_W-1:0]         seq_length;
  logic [mls_pkg::STATE_W-1:0]       seed;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign wr_len  = wr & (paddr[3] == mls_pkg::REG_SEQ_LENGTH);
  assign wr_seed = wr & (paddr[3] == mls_pkg::REG_SEED);

  assign prdata = (paddr[3] == mls_pkg::REG_SEED) ? seed
                : {{(mls_pkg::CFG_DATA_W - mls_pkg::LEN_W){1'b0}}, seq_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= mls_pkg::LEN_RESET;
      seed       <= mls_pkg::SEED_RESET;
    end else begin
      if (wr_len)  seq_length <= pwdata[mls_pkg::LEN_W-1:0];
      if (wr_seed) seed       <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-length constants, registered when the length or seed changes so the
  // tick path only sees flops: tap mask, one-hot top place, period mask.
  // Reset and any write also reload the cell row.
  // ---------------------------------------------------------------------------
  logic [mls_pkg::LEN_W-1:0]   len_src;
  logic [mls_pkg::STATE_W-1:0] seed_src;
  logic [mls_pkg::LEN_W-1:0]   len_sat;
  logic [mls_pkg::STATE_W-1:0] mask_next;
  logic [mls_pkg::STATE_W-1:0] taps_full;
  logic [mls_pkg::STATE_W-1:0] seed_masked;
  logic [MAX_LENGTH-1:0]       load_val;
  logic [MAX_LENGTH-1:0]       top_next;
  logic                        update;

  logic [mls_pkg::STATE_W-1:0] mask_r;
  logic [MAX_LENGTH-1:0]       taps_r;
  logic [MAX_LENGTH-1:0]       top_r;

  assign update   = rst | wr_len | wr_seed;
  assign len_src  = rst ? mls_pkg::LEN_RESET
                  : (wr_len ? pwdata[mls_pkg::LEN_W-1:0] : seq_length);
  assign seed_src = rst ? mls_pkg::SEED_RESET : (wr_seed ? pwdata : seed);

  // length 0 acts as 1, anything past MAX_LENGTH acts as MAX_LENGTH
  always_comb begin
    if (len_src == '0) begin
      len_sat = mls_pkg::LEN_W'(1);
    end else if (len_src > LEN_MAX) begin
      len_sat = LEN_MAX;
    end else begin
      len_sat = len_src;
    end
  end

  assign mask_next   = mls_pkg::len_mask(len_sat);
  assign taps_full   = mls_pkg::tap_mask(len_sat);
  assign seed_masked = seed_src & mask_next;

  // all-zero seed would lock up: fall back to all active bits set
  assign load_val = (seed_masked == '0) ? mask_next[MAX_LENGTH-1:0]
                                        : seed_masked[MAX_LENGTH-1:0];

  always_comb begin
    for (int i = 0; i < MAX_LENGTH; i++) begin
      top_next[i] = (len_sat == mls_pkg::LEN_W'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      mask_r <= mask_next;
      taps_r <= taps_full[MAX_LENGTH-1:0];
      top_r  <= top_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row. Bits above the top active place stay zero, so every cell can
  // simply take its left neighbor; the top one takes the feedback instead.
  // ---------------------------------------------------------------------------
  logic               accept;
  logic               push;
  logic [MAX_LENGTH-1:0] state;
  mls_pkg::cell_ctl_t ctl;

  assign accept   = s_tvalid & s_tready;
  assign push     = accept & s_tdata[0];
  assign ctl.load = update;
  assign ctl.step = push;
  assign ctl.fb   = ^(state & taps_r);

  for (genvar g = 0; g < MAX_LENGTH; g++) begin : g_cell
    logic right;
    if (g == MAX_LENGTH - 1) begin : g_end
      assign right = 1'b0;
    end else begin : g_mid
      assign right = state[g+1];
    end

    mls_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .is_top   (top_r[g]),
      .load_bit (load_val[g]),
      .right    (right),
      .q        (state[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid entry; only the emitted bit is stored. Sample follows
  // from it, period from the length, which the user must change only when idle; unchecked.
  // ---------------------------------------------------------------------------
  logic out_valid;
  logic out_bit;
  logic skid_valid;
  logic skid_bit;
  logic out_free;

  assign s_tready = ~skid_valid;
  assign out_free = ~out_valid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_bit <= skid_valid ? skid_bit : state[0];
    end
    if (!out_free && push) begin
      skid_bit <= state[0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(mls_pkg::OUT_DATA_W - mls_pkg::STATE_W - 3){1'b0}},
                     mask_r, ~out_bit, 1'b1, out_bit};

`ifndef ASSERT_OFF
  // the skid entry is only used behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // a tick arriving during a stall must land in the skid entry
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && push) |=> skid_valid)
    else $error("tick result dropped during stall");

  // the LFSR never reaches the all-zero lock-up state
  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    state != '0)
    else $error("LFSR state is zero");

  // cells above the top active place hold zero
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (state & ~mask_r[MAX_LENGTH-1:0]) == '0)
    else $error("inactive LFSR bits set");

  // exactly one cell takes the feedback
  a_top_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(top_r))
    else $error("feedback place not one-hot");
`endif

endmodule

// ----- dv/mls_sequence_generator_tb.sv -----
// Self-checking testbench for mls_sequence_generator: tick requests in, LFSR results out,
// checked against an in-bench LFSR predictor under random back-pressure and reprogramming.
// Depends on mls_pkg and the mls_sequence_generator RTL.
module mls_sequence_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned LEN_MAX         = mls_pkg::MAX_LENGTH_DEF;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned RANDOM_PHASES   = 14;

  // register byte addresses: 8 bytes per register, index from the package
  localparam logic [mls_pkg::CFG_ADDR_W-1:0] SEQ_LENGTH_ADDR = {mls_pkg::REG_SEQ_LENGTH, 3'b000};
  localparam logic [mls_pkg::CFG_ADDR_W-1:0] SEED_ADDR       = {mls_pkg::REG_SEED, 3'b000};

  localparam logic signed [1:0] SAMPLE_POS = 2'sb01;
  localparam logic signed [1:0] SAMPLE_NEG = 2'sb11;

  // one expected result
  typedef struct packed {
    logic              out_bit;
    logic signed [1:0] sample;
    logic [63:0]       period;
  } mls_word_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                              clk      = 1'b0;
  logic                              rst      = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [mls_pkg::IN_DATA_W-1:0]     s_tdata  = '0;  // [0] advance, [7:1] zero
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [mls_pkg::OUT_DATA_W-1:0]    m_tdata;        // [0] out_bit, [2:1] sample,
                                                     // [66:3] period, [71:67] zero
  logic                              psel     = 1'b0;
  logic                              penable  = 1'b0;
  logic                              pwrite   = 1'b0;
  logic [mls_pkg::CFG_ADDR_W-1:0]    paddr    = '0;
  logic [mls_pkg::CFG_DATA_W-1:0]    pwdata   = '0;
  logic [mls_pkg::CFG_DATA_W-1:0]    prdata;
  logic                              pready;

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  logic        tick_q[$];        // advance bits waiting to be sent
  mls_word_t   results_due[$];   // predicted results, oldest first
  int unsigned send_pct    = 0;  // chance per cycle of a sender gap burst
  int unsigned recv_pct    = 0;  // chance per cycle of a receiver stall burst
  int unsigned send_gap    = 0;
  int unsigned recv_gap    = 0;
  int unsigned error_count = 0;
  int unsigned cycles      = 0;

  // predictor copy of the registers and the shift register
  logic [6:0]  len_reg;
  logic [63:0] seed_reg;
  logic [63:0] lfsr;

  mls_sequence_generator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // LFSR predictor
  // ---------------------------------------------------------------------------

  // written length saturated into 1..LEN_MAX
  function automatic int unsigned active_len(input logic [6:0] n);
    if (n == 7'd0) return 1;
    if (n > LEN_MAX) return LEN_MAX;
    return int'(n);
  endfunction

  function automatic logic [63:0] ones_below(input int unsigned n);
    if (n >= 64) return {64{1'b1}};
    return (64'h1 << n) - 64'h1;
  endfunction

  // feedback taps per length: bit 0 always, plus up to three more positions
  // (zero in a slot means no tap there)
  function automatic logic [63:0] feedback_taps(input int unsigned n);
    logic [2:0][6:0] pos;
    logic [63:0]     t;
    case (n)
      2, 3, 4, 6, 7, 15, 22, 60, 63:   pos = {7'd0, 7'd0, 7'd1};
      5, 11, 21, 29, 35:               pos = {7'd0, 7'd0, 7'd2};
      10, 17, 20, 25, 28, 31, 41, 52:  pos = {7'd0, 7'd0, 7'd3};
      9, 39:                           pos = {7'd0, 7'd0, 7'd4};
      23, 47:                          pos = {7'd0, 7'd0, 7'd5};
      18, 57:                          pos = {7'd0, 7'd0, 7'd7};
      49:                              pos = {7'd0, 7'd0, 7'd9};
      36:                              pos = {7'd0, 7'd0, 7'd11};
      33:                              pos = {7'd0, 7'd0, 7'd13};
      58:                              pos = {7'd0, 7'd0, 7'd19};
      55:                              pos = {7'd0, 7'd0, 7'd24};
      13, 24, 45, 64:                  pos = {7'd4, 7'd3, 7'd1};
      8, 19, 38, 43:                   pos = {7'd6, 7'd5, 7'd1};
      26, 27:                          pos = {7'd8, 7'd7, 7'd1};
      14:                              pos = {7'd12, 7'd11, 7'd1};
      34:                              pos = {7'd15, 7'd14, 7'd1};
      30, 51, 53, 61:                  pos = {7'd16, 7'd15, 7'd1};
      46:                              pos = {7'd21, 7'd20, 7'd1};
      56, 59:                          pos = {7'd22, 7'd21, 7'd1};
      42:                              pos = {7'd23, 7'd22, 7'd1};
      44, 50:                          pos = {7'd27, 7'd26, 7'd1};
      32, 48:                          pos = {7'd28, 7'd27, 7'd1};
      54:                              pos = {7'd37, 7'd36, 7'd1};
      62:                              pos = {7'd57, 7'd56, 7'd1};
      16:                              pos = {7'd5, 7'd3, 7'd2};
      12:                              pos = {7'd7, 7'd4, 7'd3};
      37:                              pos = {7'd12, 7'd10, 7'd2};
      40:                              pos = {7'd21, 7'd19, 7'd2};
      default:                         pos = '0;  // length one: bit 0 only
    endcase
    t = 64'h1;
    for (int k = 0; k < 3; k++)
      if (pos[k] != 7'd0) t = t | (64'h1 << pos[k]);
    return t;
  endfunction

  // seed masked to the active bits; an empty register becomes all ones
  task automatic reload_lfsr();
    logic [63:0] m;
    m = ones_below(active_len(len_reg));
    lfsr = seed_reg & m;
    if (lfsr == 64'h0) lfsr = m;
  endtask

  // one tick: emit bit 0, shift right, parity of the taps into the top active bit
  function automatic mls_word_t lfsr_tick();
    int unsigned n;
    logic [63:0] m;
    logic [63:0] r;
    logic        fb;
    mls_word_t   w;
    n         = active_len(len_reg);
    m         = ones_below(n);
    r         = lfsr & m;
    w.out_bit = r[0];
    w.sample  = r[0] ? SAMPLE_POS : SAMPLE_NEG;
    w.period  = m;
    fb        = ^(r & feedback_taps(n));
    r         = (r >> 1) & ~(64'h1 << (n - 1));
    r         = r | ({63'h0, fb} << (n - 1));
    lfsr      = r & m;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input logic [mls_pkg::OUT_DATA_W-1:0] d);
    mls_word_t want;
    if (results_due.size() == 0) begin
      flag_error($sformatf("result with none outstanding, tdata %h", d));
      return;
    end
    want = results_due.pop_front();
    if (d[0] !== want.out_bit)
      flag_error($sformatf("out_bit %b, want %b", d[0], want.out_bit));
    if (d[2:1] !== want.sample)
      flag_error($sformatf("sample %b, want %b", d[2:1], want.sample));
    if (d[66:3] !== want.period)
      flag_error($sformatf("period %h, want %h", d[66:3], want.period));
  endtask

  // ---------------------------------------------------------------------------
  // config port watcher: keeps the predictor's registers in step with the DUT
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      len_reg  = mls_pkg::LEN_RESET;
      seed_reg = mls_pkg::SEED_RESET;
      lfsr     = {64{1'b1}};
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == SEQ_LENGTH_ADDR) begin
        len_reg = pwdata[6:0];
        reload_lfsr();
      end else if (paddr == SEED_ADDR) begin
        seed_reg = pwdata;
        reload_lfsr();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tick driver: pops requests from tick_q, random gap bursts between them.
  // Prediction happens here, at the edge where the request is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : tick_driver
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        if (s_tdata[0]) results_due.push_back(lfsr_tick());
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (tick_q.size() != 0) begin
          if ($urandom_range(0, 99) < send_pct) begin
            send_gap = $urandom_range(0, 5);  // idle burst before the next request
          end else begin
            s_tdata <= {7'b0, tick_q.pop_front()};
            offer = 1'b1;
          end
        end
      end
      s_tvalid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor with random stall bursts on m_tready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    logic take;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      take = 1'b1;
      if (recv_gap > 0) begin
        recv_gap--;
        take = 1'b0;
      end else if ($urandom_range(0, 99) < recv_pct) begin
        recv_gap = $urandom_range(0, 5);
        take = 1'b0;
      end
      m_tready <= take;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("mls_sequence_generator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // setup then access phase; the register takes the value at the access edge
  task automatic cfg_write(input logic [mls_pkg::CFG_ADDR_W-1:0] addr, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // n requests, skip_pct percent of them with advance low (no result)
  task automatic queue_ticks(input int unsigned n, input int unsigned skip_pct);
    for (int unsigned k = 0; k < n; k++)
      tick_q.push_back($urandom_range(0, 99) >= skip_pct);
  endtask

  // sender holds off until every request is out and every result back; the trailing
  // clocks after that cover a no-result request still in the block
  task automatic drain();
    do @(negedge clk);
    while (tick_q.size() != 0 || s_tvalid || results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_length();
    case ($urandom_range(0, 11))
      0:       return 7'd0;                         // acts as one
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;                       // acts as 64
      4:       return 7'($urandom_range(65, 126));
      5:       return 7'($urandom_range(2, 5));     // short period, wraps often
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return 64'h0;                        // zero reloads all ones
      1:       return {64{1'b1}};
      2:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 8;
      2:       return 20;
      default: return 35;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [6:0]  len;
    logic [63:0] sd;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents at full length, with one no-result request
    send_pct = 15;
    recv_pct = 20;
    queue_ticks(2, 0);
    tick_q.push_back(1'b0);
    queue_ticks(2, 0);
    drain();

    // length one stays at constant ones
    cfg_write(SEQ_LENGTH_ADDR, 64'd1);
    queue_ticks(3, 0);
    drain();

    // length zero behaves as one
    cfg_write(SEQ_LENGTH_ADDR, 64'd0);
    queue_ticks(2, 0);
    drain();

    // oversize length saturates to the maximum, all-ones seed
    cfg_write(SEQ_LENGTH_ADDR, 64'd127);
    cfg_write(SEED_ADDR, {64{1'b1}});
    queue_ticks(2, 0);
    drain();

    // seed bits all above the active length: masked to zero, reload all ones
    cfg_write(SEQ_LENGTH_ADDR, 64'd4);
    cfg_write(SEED_ADDR, 64'hF0);
    queue_ticks(4, 0);
    drain();

    // smallest real LFSR
    cfg_write(SEQ_LENGTH_ADDR, 64'd2);
    cfg_write(SEED_ADDR, 64'h2);
    queue_ticks(3, 0);
    drain();

    // just past the maximum, seed with top and bottom bits set
    cfg_write(SEQ_LENGTH_ADDR, 64'd65);
    cfg_write(SEED_ADDR, 64'h8000_0000_0000_0001);
    queue_ticks(2, 0);
    drain();

    // random phases: reprogram while idle, then a burst of requests
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      len = pick_length();
      sd  = pick_seed();
      case ($urandom_range(0, 3))
        0: begin
          cfg_write(SEED_ADDR, sd);
          cfg_write(SEQ_LENGTH_ADDR, {57'b0, len});
        end
        1: cfg_write(SEQ_LENGTH_ADDR, {57'b0, len});
        2: cfg_write(SEED_ADDR, sd);
        default: begin
          cfg_write(SEQ_LENGTH_ADDR, {57'b0, len});
          cfg_write(SEED_ADDR, sd);
        end
      endcase
      // last phase runs flat out on both sides
      if (phase == RANDOM_PHASES - 1) begin
        send_pct = 0;
        recv_pct = 0;
      end else begin
        send_pct = pick_pct();
        recv_pct = pick_pct();
      end
      queue_ticks($urandom_range(60, 90), 10);
      drain();
    end

    // catch any stray result after the last one
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("mls_sequence_generator regression: pass");
    else
      $display("mls_sequence_generator regression: fail");
    $finish;
  end

endmodule
